// ===== rtl/seven_segment_text_scanner_core_defines.svh =====
// ---------------------------------------------------------------------------
// seven_segment_text_scanner_core_defines.svh
// assertion macros shared by the scanner rtl
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TEXT_SCANNER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_TEXT_SCANNER_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define SSTS_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("scanner check failed: same-cycle condition");

// condition must hold in the cycle after the trigger
`define SSTS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("scanner check failed: next-cycle condition");

`endif

// ===== rtl/ssts_pkg.sv =====
// ---------------------------------------------------------------------------
// ssts_pkg
// constants, segment table and glyph lookup for the text scanner
// ---------------------------------------------------------------------------
package ssts_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int SLOT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int FILL_W     = $clog2(NUM_DIGITS + 1);
  localparam int DEN_W      = 4;

  // request kinds carried in tuser
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // character codes
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  localparam logic [7:0] MINUS_PATTERN = 8'd8;
  localparam logic [7:0] OTHER_PATTERN = 8'd127;
  localparam logic [7:0] POINT_BIT     = 8'd128;
  localparam logic [7:0] INVERT_MASK   = 8'hFF;

  typedef logic [7:0] seg_t;

  localparam seg_t HEX_SEGMENTS [16] = '{
    8'h77, 8'h60, 8'h3E, 8'h7C, 8'h69, 8'h5D, 8'h5F, 8'h64,
    8'h7F, 8'h7D, 8'h6F, 8'h5B, 8'h17, 8'h7A, 8'h1F, 8'h0F
  };

  function automatic seg_t glyph(input logic [7:0] c);
    seg_t g;
    g = OTHER_PATTERN;
    if (c == CHAR_MINUS) begin
      g = MINUS_PATTERN;
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      g = HEX_SEGMENTS[4'(c - CHAR_0)];
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      g = HEX_SEGMENTS[4'(c - CHAR_LA + 8'd10)];
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      g = HEX_SEGMENTS[4'(c - CHAR_UA + 8'd10)];
    end
    return g;
  endfunction

endpackage

// ===== rtl/seven_segment_text_scanner_core.sv =====
// ---------------------------------------------------------------------------
// seven_segment_text_scanner_core
// multiplexed seven-segment driver: fills digit slots from text, scans them
//
//   channel   dir  fields (low bit up)
//   s_axis    in   tuser: req_type, tdata: char_code, tlast: end_of_text
//   m_axis    out  tdata: shift_byte, digit_enable, zero pad
//
// one beat per cycle on the input while not stalled; the slot update and the scan lookup are
// both single-level logic ahead of the state and result registers
// a tick beat shows up on m_axis the cycle after it is taken
// the result register is the only buffer: a full register that is not
// being drained stalls the input
// rst is synchronous active high and clears slots, fill, hold and scan state
// ---------------------------------------------------------------------------
`include "seven_segment_text_scanner_core_defines.svh"

module seven_segment_text_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tuser,   // req_type
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // shift_byte, digit_enable, zero pad
);

  localparam int N      = ssts_pkg::NUM_DIGITS;
  localparam int SLOT_W = ssts_pkg::SLOT_W;
  localparam int FILL_W = ssts_pkg::FILL_W;
  localparam int DEN_W  = ssts_pkg::DEN_W;

  // display state
  ssts_pkg::seg_t    slots [N];
  logic [FILL_W-1:0] fill_position;
  logic              held_valid;
  logic [7:0]        held_char;
  logic [SLOT_W-1:0] scan_position;

  ssts_pkg::seg_t    slots_next [N];
  logic [FILL_W-1:0] fill_position_next;
  logic              held_valid_next;
  logic [7:0]        held_char_next;
  logic [SLOT_W-1:0] scan_position_next;

  // result register
  logic              out_valid;
  ssts_pkg::seg_t    out_shift;
  logic [DEN_W-1:0]  out_enable;

  logic              in_beat;
  logic              is_tick;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (s_axis_tuser == ssts_pkg::REQ_TICK);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(16 - 8 - DEN_W){1'b0}}, out_enable, out_shift};

  // character path: the held character is written once we know whether a
  // point follows; end of text flushes it and rewinds to slot 0
  always_comb begin
    slots_next         = slots;
    fill_position_next = fill_position;
    held_valid_next    = held_valid;
    held_char_next     = held_char;

    if (held_valid) begin
      // write out the held character, with the point if this beat is '.'
      if (fill_position_next < FILL_W'(N)) begin
        slots_next[fill_position_next[SLOT_W-1:0]] =
          ssts_pkg::glyph(held_char_next) |
          ((s_axis_tdata == ssts_pkg::CHAR_DOT) ? ssts_pkg::POINT_BIT : 8'd0);
        fill_position_next = fill_position_next + FILL_W'(1);
      end
      held_valid_next = 1'b0;
      if (s_axis_tdata != ssts_pkg::CHAR_DOT && fill_position_next < FILL_W'(N)) begin
        held_char_next  = s_axis_tdata;
        held_valid_next = 1'b1;
      end
    end else if (fill_position < FILL_W'(N)) begin
      // nothing held, so even a leading point is held as a plain character
      held_char_next  = s_axis_tdata;
      held_valid_next = 1'b1;
    end

    if (s_axis_tlast) begin
      if (held_valid_next && fill_position_next < FILL_W'(N)) begin
        slots_next[fill_position_next[SLOT_W-1:0]] = ssts_pkg::glyph(held_char_next);
      end
      fill_position_next = '0;
      held_valid_next    = 1'b0;
    end
  end

  // scan path: wrap after the last digit
  assign scan_position_next = (scan_position == SLOT_W'(N - 1)) ? '0
                            : scan_position + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        slots[i] <= '0;
      end
      fill_position <= '0;
      held_valid    <= 1'b0;
      held_char     <= '0;
      scan_position <= '0;
    end else if (in_beat) begin
      if (is_tick) begin
        scan_position <= scan_position_next;
      end else begin
        slots         <= slots_next;
        fill_position <= fill_position_next;
        held_valid    <= held_valid_next;
        held_char     <= held_char_next;
      end
    end
  end

  // result valid: set by an accepted tick, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat && is_tick) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload: inverted pattern and one-hot enable of the shown digit
  always_ff @(posedge clk) begin
    if (in_beat && is_tick) begin
      out_shift  <= slots[scan_position] ^ ssts_pkg::INVERT_MASK;
      out_enable <= DEN_W'(1) << scan_position;
    end
  end

  `SSTS_ASSERT_NOW(a_fill_range, 1'b1, fill_position <= FILL_W'(N))
  `SSTS_ASSERT_NEXT(a_tick_gives_beat, in_beat && is_tick, out_valid)
  `SSTS_ASSERT_NEXT(a_text_end_rewinds, in_beat && !is_tick && s_axis_tlast,
    fill_position == '0 && !held_valid)
  `SSTS_ASSERT_NOW(a_enable_onehot, out_valid, $onehot0(out_enable))

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the seven-segment text scanner: text and tick
// beats go in on s_axis, a scoreboard tracks slot, hold and scan state and
// checks every scan beat that leaves on m_axis
// ---------------------------------------------------------------------------
module tb_top;

  // segment shapes of the hex digits 0..f, bit 7 is the point
  localparam logic [7:0] HEX_SHAPE [16] = '{
    8'h77, 8'h60, 8'h3E, 8'h7C, 8'h69, 8'h5D, 8'h5F, 8'h64,
    8'h7F, 8'h7D, 8'h6F, 8'h5B, 8'h17, 8'h7A, 8'h1F, 8'h0F
  };

  typedef struct packed {
    logic [7:0]                 shift_byte;
    logic [ssts_pkg::DEN_W-1:0] digit_en;
  } scan_beat_t;

  // tracks what the display holds and which digit the next tick shows
  class scan_scoreboard;
    logic [7:0]                  slot_pat [ssts_pkg::NUM_DIGITS];
    logic [ssts_pkg::FILL_W-1:0] fill_pos;
    logic                        held_ok;
    logic [7:0]                  held_ch;
    logic [ssts_pkg::SLOT_W-1:0] scan_pos;
    scan_beat_t                  want_q [$];
    int                          mismatches;
    int                          results_seen;

    function new();
      foreach (slot_pat[i]) slot_pat[i] = '0;
      fill_pos     = '0;
      held_ok      = 1'b0;
      held_ch      = '0;
      scan_pos     = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function logic [7:0] seg_for_char(logic [7:0] c);
      if (c == ssts_pkg::CHAR_MINUS) return ssts_pkg::MINUS_PATTERN;
      if (c inside {[ssts_pkg::CHAR_0:ssts_pkg::CHAR_9]})
        return HEX_SHAPE[4'(c - ssts_pkg::CHAR_0)];
      if (c inside {[ssts_pkg::CHAR_LA:ssts_pkg::CHAR_LF]})
        return HEX_SHAPE[4'(c - ssts_pkg::CHAR_LA + 8'd10)];
      if (c inside {[ssts_pkg::CHAR_UA:ssts_pkg::CHAR_UF]})
        return HEX_SHAPE[4'(c - ssts_pkg::CHAR_UA + 8'd10)];
      return ssts_pkg::OTHER_PATTERN;
    endfunction

    // write the held character into the next free slot, with or without point
    function void write_held(logic point);
      logic [7:0] p;
      if (held_ok && fill_pos < ssts_pkg::NUM_DIGITS) begin
        p = seg_for_char(held_ch);
        if (point) p = p | ssts_pkg::POINT_BIT;
        slot_pat[fill_pos[ssts_pkg::SLOT_W-1:0]] = p;
        fill_pos = fill_pos + 1'b1;
      end
      held_ok = 1'b0;
    endfunction

    function void note_beat(logic req, logic [7:0] ch, logic last);
      scan_beat_t want;
      if (req == ssts_pkg::REQ_TICK) begin
        want.shift_byte = slot_pat[scan_pos] ^ ssts_pkg::INVERT_MASK;
        want.digit_en   = ssts_pkg::DEN_W'(1 << scan_pos);
        want_q.push_back(want);
        scan_pos = (scan_pos == ssts_pkg::NUM_DIGITS - 1) ? '0 : scan_pos + 1'b1;
        return;
      end
      if (held_ok) begin
        if (ch == ssts_pkg::CHAR_DOT) begin
          write_held(1'b1);
        end else begin
          write_held(1'b0);
          if (fill_pos < ssts_pkg::NUM_DIGITS) begin
            held_ch = ch;
            held_ok = 1'b1;
          end
        end
      end else if (fill_pos < ssts_pkg::NUM_DIGITS) begin
        held_ch = ch;
        held_ok = 1'b1;
      end
      // end of text flushes the hold and restarts at slot 0
      if (last) begin
        write_held(1'b0);
        fill_pos = '0;
        held_ok  = 1'b0;
      end
    endfunction

    function void report(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_result(logic [15:0] data);
      scan_beat_t want;
      results_seen++;
      if (want_q.size() == 0) begin
        report("unexpected scan beat", 16'h0, data);
        return;
      end
      want = want_q.pop_front();
      if (data[7:0] !== want.shift_byte)
        report("shift_byte", 16'(want.shift_byte), 16'(data[7:0]));
      if (data[11:8] !== want.digit_en)
        report("digit_enable", 16'(want.digit_en), 16'(data[11:8]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // char_code
  logic        s_axis_tuser;   // req_type
  logic        s_axis_tlast;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // shift_byte, digit_enable, zero pad

  scan_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;
  int beats_sent;
  int chars_sent;
  int ticks_sent;
  int texts_sent;

  seven_segment_text_scanner_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input logic req, input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    board.note_beat(req, ch, last);
    beats_sent++;
    if (req == ssts_pkg::REQ_TICK) begin
      ticks_sent++;
    end else begin
      chars_sent++;
      if (last) texts_sent++;
    end
    @(negedge clk);
  endtask

  // data and end marker are don't-care on ticks, so they stay random
  task automatic send_tick();
    send_beat(ssts_pkg::REQ_TICK, 8'($urandom), 1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] pick_char();
    int roll;
    int k;
    roll = $urandom_range(99);
    k    = $urandom_range(15);
    if (roll < 20) return ssts_pkg::CHAR_0 + 8'($urandom_range(9));
    if (roll < 30) return ssts_pkg::CHAR_LA + 8'($urandom_range(5));
    if (roll < 40) return ssts_pkg::CHAR_UA + 8'($urandom_range(5));
    if (roll < 50) return ssts_pkg::CHAR_MINUS;
    if (roll < 68) return ssts_pkg::CHAR_DOT;
    // neighbors of the decoded ranges
    if (roll < 78) begin
      case (k % 6)
        0: return ssts_pkg::CHAR_0 - 8'd1;
        1: return ssts_pkg::CHAR_9 + 8'd1;
        2: return ssts_pkg::CHAR_LA - 8'd1;
        3: return ssts_pkg::CHAR_LF + 8'd1;
        4: return ssts_pkg::CHAR_UA - 8'd1;
        default: return ssts_pkg::CHAR_UF + 8'd1;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic directed_texts();
    repeat (4) send_tick();               // reset state shows all dark, enables wrap
    // point on the first digit, both cases, minus, text exactly fills the slots
    send_beat(ssts_pkg::REQ_CHAR, "0", 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, ssts_pkg::CHAR_DOT, 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, "f", 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, "A", 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, ssts_pkg::CHAR_MINUS, 1'b1);
    repeat (4) send_tick();
    // leading point followed by a point, then an unknown code flushed at the end
    send_beat(ssts_pkg::REQ_CHAR, ssts_pkg::CHAR_DOT, 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, ssts_pkg::CHAR_DOT, 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, 8'hFF, 1'b1);
    // overlong text: point on the fourth digit, the rest dropped
    send_beat(ssts_pkg::REQ_CHAR, "9", 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, "F", 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, "a", 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, 8'h00, 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, ssts_pkg::CHAR_DOT, 1'b0);
    send_beat(ssts_pkg::REQ_CHAR, "Z", 1'b1);
    repeat (4) send_tick();
  endtask

  task automatic random_phase(input int beats_wanted);
    int start;
    int len;
    int k;
    logic closed;
    start = beats_sent;
    while (beats_sent - start < beats_wanted) begin
      if ($urandom_range(9) == 0) begin
        // noise: any kind, any code, any end marker
        send_beat(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
      end else begin
        len    = ($urandom_range(7) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
        closed = ($urandom_range(9) != 0);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(9) < 2) send_tick();
          send_beat(ssts_pkg::REQ_CHAR, pick_char(), closed && (k == len - 1));
        end
        repeat ($urandom_range(0, 6)) send_tick();
      end
    end
  endtask

  initial begin : stimulus
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ssts_pkg::REQ_CHAR;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    beats_sent     = 0;
    chars_sent     = 0;
    ticks_sent     = 0;
    texts_sent     = 0;
    send_idle_pct  = 24;
    recv_stall_pct = 81;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_texts();
    random_phase(210);
    send_idle_pct  = 81;
    recv_stall_pct = 24;
    random_phase(210);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(210);
    s_axis_tvalid <= 1'b0;

    while (board.want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d text beats in %0d closed texts and %0d scan ticks",
             chars_sent, texts_sent, ticks_sent);
    $display("checked %0d scan beats, %0d mismatches", board.results_seen, board.mismatches);
    if (board.mismatches == 0 && board.want_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("timeout with %0d scan beats outstanding", board.want_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ssts_pkg.sv
rtl/seven_segment_text_scanner_core.sv
bench/tb_top.sv
